// ----- hw/rtl/arabic_to_roman_numeral_encoder_top_macros.svh -----
// assertion macros for the roman numeral encoder
// used by the top level only, clocked on aclk and disabled while aresetn is low
`ifndef ARABIC_TO_ROMAN_NUMERAL_ENCODER_TOP_MACROS_SVH
`define ARABIC_TO_ROMAN_NUMERAL_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define A2R_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("a2r: same-cycle check failed");
`define A2R_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("a2r: next-cycle check failed");
`else
`define A2R_ASSERT_IMPL(label, ante, cons)
`define A2R_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hw/rtl/a2r_pkg.sv -----
// types, letter codes and lookup functions for the roman numeral encoder
// no dependencies; imported by a2r_extract and the top level
package a2r_pkg;

    localparam int NUM_W   = 14;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;
    localparam int STEP_W  = 4;

    localparam logic [STEP_W-1:0] STEP_LAST = 4'd12;

    localparam logic [CHAR_W-1:0] CH_M = 7'h4D;
    localparam logic [CHAR_W-1:0] CH_D = 7'h44;
    localparam logic [CHAR_W-1:0] CH_C = 7'h43;
    localparam logic [CHAR_W-1:0] CH_L = 7'h4C;
    localparam logic [CHAR_W-1:0] CH_X = 7'h58;
    localparam logic [CHAR_W-1:0] CH_V = 7'h56;
    localparam logic [CHAR_W-1:0] CH_I = 7'h49;

    localparam logic [1:0] POS_THOU = 2'd0;
    localparam logic [1:0] POS_HUND = 2'd1;
    localparam logic [1:0] POS_TENS = 2'd2;
    localparam logic [1:0] POS_ONES = 2'd3;

    typedef struct packed {
        logic [DIGIT_W-1:0] thou;
        logic [DIGIT_W-1:0] hund;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } a2r_digits_t;

    // weight subtracted at each step of the digit extraction
    function automatic logic [NUM_W-1:0] step_weight(input logic [STEP_W-1:0] step);
        logic [NUM_W-1:0] w;
        unique case (step)
            4'd0:    w = 14'd10000;
            4'd1:    w = 14'd8000;
            4'd2:    w = 14'd4000;
            4'd3:    w = 14'd2000;
            4'd4:    w = 14'd1000;
            4'd5:    w = 14'd800;
            4'd6:    w = 14'd400;
            4'd7:    w = 14'd200;
            4'd8:    w = 14'd100;
            4'd9:    w = 14'd80;
            4'd10:   w = 14'd40;
            4'd11:   w = 14'd20;
            4'd12:   w = 14'd10;
            default: w = '0;
        endcase
        return w;
    endfunction

    // number of letters a digit produces
    function automatic logic [DIGIT_W-1:0] digit_len(input logic is_thou,
                                                     input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] n;
        unique case (d)
            4'd1:    n = 4'd1;
            4'd2:    n = 4'd2;
            4'd3:    n = 4'd3;
            4'd4:    n = 4'd2;
            4'd5:    n = 4'd1;
            4'd6:    n = 4'd2;
            4'd7:    n = 4'd3;
            4'd8:    n = 4'd4;
            4'd9:    n = 4'd2;
            default: n = 4'd0;
        endcase
        return is_thou ? d : n;
    endfunction

    // letter number k of digit d at decimal position pos
    function automatic logic [CHAR_W-1:0] digit_letter(input logic [1:0] pos,
                                                       input logic [DIGIT_W-1:0] d,
                                                       input logic [DIGIT_W-1:0] k);
        logic [CHAR_W-1:0] one_ch;
        logic [CHAR_W-1:0] five_ch;
        logic [CHAR_W-1:0] ten_ch;
        logic [CHAR_W-1:0] ch;
        unique case (pos)
            POS_HUND: begin one_ch = CH_C; five_ch = CH_D; ten_ch = CH_M; end
            POS_TENS: begin one_ch = CH_X; five_ch = CH_L; ten_ch = CH_C; end
            POS_ONES: begin one_ch = CH_I; five_ch = CH_V; ten_ch = CH_X; end
            default:  begin one_ch = CH_M; five_ch = CH_M; ten_ch = CH_M; end
        endcase
        if (pos == POS_THOU) begin
            ch = CH_M;
        end else if (d == 4'd9) begin
            ch = (k == '0) ? one_ch : ten_ch;
        end else if (d == 4'd4) begin
            ch = (k == '0) ? one_ch : five_ch;
        end else if (d >= 4'd5) begin
            ch = (k == '0) ? five_ch : one_ch;
        end else begin
            ch = one_ch;
        end
        return ch;
    endfunction

endpackage

// ----- hw/rtl/arabic_to_roman_numeral_encoder_top.sv -----
// roman numeral encoder top level: input transfer, letter sequencer, output register
// depends on a2r_pkg, a2r_extract and the assertion macro header
//
//  channel  dir  tdata                     tuser  tlast
//  s_       in   [13:0] number_in          -      -
//  m_       out  [6:0]  roman_char         -      last_char
//
// one number is accepted while idle, extracted in 13 subtract steps and a digit
// hand-over, then sent at one letter per cycle (up to 21) unless m_ stalls, with
// leading or inner zero digits passed over; a zero number sends no letters
// s_tready is high only while idle; a stalled m_ side holds the letter sequencer
// reset is synchronous, active low, and returns the block to idle with no output
`include "arabic_to_roman_numeral_encoder_top_macros.svh"
module arabic_to_roman_numeral_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [13:0] number_in, [15:14] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] roman_char, [7] zero
    output logic        m_tlast
);
    import a2r_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_EXTRACT = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [1:0]          pos_reg, pos_next;
    logic [DIGIT_W-1:0]  k_reg, k_next;
    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   m_char_reg, m_char_next;
    logic                m_last_reg, m_last_next;

    logic                start;
    logic                ext_done;
    a2r_digits_t         digits;
    logic [DIGIT_W-1:0]  cur_digit;
    logic [DIGIT_W-1:0]  cur_len;
    logic                rest_zero;
    logic                digit_end;
    logic                is_last;
    logic                load_ok;
    logic                all_zero;

    assign s_tready = (state_reg == ST_IDLE);
    assign start    = s_tvalid & s_tready;

    a2r_extract u_extract (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .number  (s_tdata[NUM_W-1:0]),
        .done    (ext_done),
        .digits  (digits)
    );

    always_comb begin
        unique case (pos_reg)
            POS_THOU: begin
                cur_digit = digits.thou;
                rest_zero = (digits.hund == '0) && (digits.tens == '0) && (digits.ones == '0);
            end
            POS_HUND: begin
                cur_digit = digits.hund;
                rest_zero = (digits.tens == '0) && (digits.ones == '0);
            end
            POS_TENS: begin
                cur_digit = digits.tens;
                rest_zero = (digits.ones == '0);
            end
            default: begin
                cur_digit = digits.ones;
                rest_zero = 1'b1;
            end
        endcase
    end

    assign cur_len   = digit_len(pos_reg == POS_THOU, cur_digit);
    assign digit_end = (k_reg == cur_len - 4'd1);
    assign is_last   = digit_end & rest_zero;
    assign load_ok   = ~m_valid_reg | m_tready;
    assign all_zero  = (digits == '0);

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_EXTRACT;
                end
            end
            ST_EXTRACT: begin
                if (ext_done) begin
                    state_next = all_zero ? ST_IDLE : ST_EMIT;
                    pos_next   = POS_THOU;
                    k_next     = '0;
                end
            end
            ST_EMIT: begin
                if (cur_len == '0) begin
                    // zero digit, nothing to send
                    pos_next = pos_reg + 2'd1;
                end else if (load_ok) begin
                    m_valid_next = 1'b1;
                    m_char_next  = digit_letter(pos_reg, cur_digit, k_reg);
                    m_last_next  = is_last;
                    if (digit_end) begin
                        pos_next = pos_reg + 2'd1;
                        k_next   = '0;
                    end else begin
                        k_next = k_reg + 4'd1;
                    end
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= POS_THOU;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_last_reg;

    `A2R_ASSERT_NEXT(a_accept_to_extract, start, state_reg == ST_EXTRACT)
    `A2R_ASSERT_NEXT(a_last_to_idle,
        (state_reg == ST_EMIT) && load_ok && (cur_len != '0) && is_last,
        (state_reg == ST_IDLE) && m_tvalid && m_tlast)
    `A2R_ASSERT_IMPL(a_letter_code, m_tvalid,
        (m_tdata[6:0] == CH_M) || (m_tdata[6:0] == CH_D) || (m_tdata[6:0] == CH_C) ||
        (m_tdata[6:0] == CH_L) || (m_tdata[6:0] == CH_X) || (m_tdata[6:0] == CH_V) ||
        (m_tdata[6:0] == CH_I))

endmodule

// ----- hw/rtl/a2r_extract.sv -----
// decimal digit extraction by restoring subtraction, one weight per cycle
// depends on a2r_pkg; one shared compare and subtract for all 13 steps
module a2r_extract (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [a2r_pkg::NUM_W-1:0] number,
    output logic                      done,
    output a2r_pkg::a2r_digits_t      digits
);
    import a2r_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [NUM_W-1:0]    rem_reg, rem_next;
    logic [DIGIT_W-1:0]  acc_reg, acc_next;
    a2r_digits_t         digits_reg, digits_next;

    logic [NUM_W-1:0]    weight;
    logic [NUM_W:0]      diff;
    logic                ge;

    // shared subtractor
    assign weight = step_weight(step_reg);
    assign diff   = {1'b0, rem_reg} - {1'b0, weight};
    assign ge     = ~diff[NUM_W];

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        rem_next    = rem_reg;
        acc_next    = acc_reg;
        digits_next = digits_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = number;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[NUM_W-1:0] : rem_reg;
            acc_next  = {acc_reg[DIGIT_W-2:0], ge};
            step_next = step_reg + 4'd1;
            case (step_reg)
                4'd4:  digits_next.thou = acc_next;
                4'd8:  digits_next.hund = acc_next;
                default: ;
            endcase
            if (step_reg == STEP_LAST) begin
                digits_next.tens = acc_next;
                digits_next.ones = rem_next[DIGIT_W-1:0];
                busy_next        = 1'b0;
                done_next        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg    <= rem_next;
        acc_reg    <= acc_next;
        digits_reg <= digits_next;
    end

    assign done   = done_reg;
    assign digits = digits_reg;

endmodule
